/* hdl/i2c_bit_level_master_unit_macros.svh */
// Assertion macros shared by the I2C bit-level master RTL.
`ifndef I2C_BIT_LEVEL_MASTER_UNIT_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_UNIT_MACROS_SVH

// I2CBL_ASSERT checks a property on clk and skips cycles while rst_n is low.
// I2CBL_ASSERT_NR checks a property on clk at every edge, reset included.
`ifndef ASSERT_OFF
`define I2CBL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2c bit-level master: assertion failed");
`define I2CBL_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("i2c bit-level master: reset assertion failed");
`else
`define I2CBL_ASSERT(lbl, prop)
`define I2CBL_ASSERT_NR(lbl, prop)
`endif

`endif

/* hdl/i2cbl_pkg.sv */
// Types, state codes and constants of the I2C bit-level master.
package i2cbl_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam logic [3:0] BITC_FULL = 4'(BYTE_BITS);
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_START     = 3'd1;
  localparam logic [2:0] MODE_STOP      = 3'd2;
  localparam logic [2:0] MODE_WRITE     = 3'd3;
  localparam logic [2:0] MODE_READ_ACK  = 3'd4;
  localparam logic [2:0] MODE_READ_NACK = 3'd5;

  typedef enum logic [18:0] {
    ST_IDLE = 19'h00001,
    ST_S_A  = 19'h00002,
    ST_S_B  = 19'h00004,
    ST_S_C  = 19'h00008,
    ST_S_D  = 19'h00010,
    ST_P_A  = 19'h00020,
    ST_P_B  = 19'h00040,
    ST_P_C  = 19'h00080,
    ST_W_A  = 19'h00100,
    ST_W_B  = 19'h00200,
    ST_W_C  = 19'h00400,
    ST_K_A  = 19'h00800,
    ST_K_B  = 19'h01000,
    ST_POLL = 19'h02000,
    ST_R_A  = 19'h04000,
    ST_R_B  = 19'h08000,
    ST_A_A  = 19'h10000,
    ST_A_B  = 19'h20000,
    ST_FIN  = 19'h40000
  } step_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } line_t;

  typedef struct packed {
    step_t      step;
    logic [7:0] timer;
    line_t      line;
  } seq_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack;
  } out_item_t;

endpackage

/* hdl/i2cbl_seq.sv */
// Line sequencer of the I2C bit-level master: state registers and one-tick step logic.
`include "i2c_bit_level_master_unit_macros.svh"

module i2cbl_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  i2cbl_pkg::in_item_t  item,
  input  logic [7:0]           ack_timeout,
  output i2cbl_pkg::out_item_t res
);
  import i2cbl_pkg::*;

  step_t      step_r,  step_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic [3:0] bitc_r,  bitc_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       ackr_r,  ackr_nxt;
  line_t      line_r,  line_nxt;
  logic       nack_r,  nack_nxt;
  logic [7:0] rbyte_r, rbyte_nxt;

  // Levels and delay set on entry to a segment.
  function automatic seq_t enter_st(input step_t s, input line_t ln, input logic msb,
                                    input logic ackr);
    seq_t r;
    r.step  = s;
    r.timer = 8'd0;
    r.line  = ln;
    case (s)
      ST_S_A: begin r.line.drv = 1'b1; r.line.sda = 1'b1; r.timer = 8'd1; end
      ST_S_B: begin r.line.scl = 1'b1; r.timer = 8'd5; end
      ST_S_C: begin r.line.sda = 1'b0; r.timer = 8'd6; end
      ST_S_D: begin r.line.scl = 1'b0; r.timer = 8'd2; end
      ST_P_A: begin
        r.line.drv = 1'b1; r.line.scl = 1'b0; r.line.sda = 1'b0; r.timer = 8'd4;
      end
      ST_P_B: begin r.line.scl = 1'b1; r.timer = 8'd6; end
      ST_P_C: begin r.line.sda = 1'b1; r.timer = 8'd6; end
      ST_W_A: begin
        r.line.drv = 1'b1; r.line.scl = 1'b0; r.line.sda = msb; r.timer = 8'd2;
      end
      ST_W_B: begin r.line.scl = 1'b1; r.timer = 8'd2; end
      ST_W_C: begin r.line.scl = 1'b0; r.timer = 8'd2; end
      ST_K_A: begin r.line.drv = 1'b0; r.line.sda = 1'b1; r.timer = 8'd2; end
      ST_K_B: begin r.line.scl = 1'b1; r.timer = 8'd2; end
      ST_R_A: begin r.line.drv = 1'b0; r.line.scl = 1'b0; r.timer = 8'd2; end
      ST_R_B: begin r.line.scl = 1'b1; r.timer = 8'd1; end
      ST_A_A: begin
        r.line.scl = 1'b0; r.line.drv = 1'b1; r.line.sda = ~ackr; r.timer = 8'd2;
      end
      ST_A_B: begin r.line.scl = 1'b1; r.timer = 8'd5; end
      default: r.timer = 8'd0;
    endcase
    return r;
  endfunction

  always_comb begin : step_logic
    step_t      stp;
    logic [7:0] tmr;
    logic [3:0] bc;
    logic [7:0] sh;
    logic       ak;
    line_t      ln;
    logic       nk;
    logic [7:0] rb;
    line_t      oln;
    logic       busy;
    logic       done;
    logic       go;
    step_t      tgt;
    seq_t       e;

    stp  = step_r;
    tmr  = timer_r;
    bc   = bitc_r;
    sh   = shift_r;
    ak   = ackr_r;
    ln   = line_r;
    nk   = nack_r;
    rb   = rbyte_r;
    busy = 1'b0;
    done = 1'b0;
    go   = 1'b0;
    tgt  = ST_IDLE;

    // A command is taken only while idle; its first segment shows this tick.
    if (stp == ST_IDLE) begin
      bc = 4'd0;
      go = 1'b1;
      case (item.mode)
        MODE_START: tgt = ST_S_A;
        MODE_STOP:  tgt = ST_P_A;
        MODE_WRITE: begin
          sh  = item.write_data;
          nk  = 1'b0;
          tgt = ST_W_A;
        end
        MODE_READ_ACK: begin
          sh  = 8'd0;
          ak  = 1'b1;
          tgt = ST_R_A;
        end
        MODE_READ_NACK: begin
          sh  = 8'd0;
          ak  = 1'b0;
          tgt = ST_R_A;
        end
        default: go = 1'b0;
      endcase
      if (go) begin
        e   = enter_st(tgt, ln, sh[7], ak);
        stp = e.step;
        tmr = e.timer;
        ln  = e.line;
      end
    end

    oln = ln;
    go  = 1'b0;
    tgt = ST_IDLE;

    if (stp == ST_FIN) begin
      done = 1'b1;
      stp  = ST_IDLE;
    end else if (stp == ST_POLL) begin
      busy = 1'b1;
      if (!item.sda_level) begin
        ln.scl = 1'b0;
        stp    = ST_FIN;
        tmr    = 8'd0;
      end else if (tmr >= ack_timeout) begin
        nk  = 1'b1;
        go  = 1'b1;
        tgt = ST_P_A;
      end else begin
        tmr = tmr + 8'd1;
      end
    end else if (stp != ST_IDLE) begin
      busy = 1'b1;
      // Read bits are sampled on the tick SCL goes high.
      if (stp == ST_R_B && tmr == 8'd1) begin
        sh = {sh[6:0], item.sda_level};
        bc = bc + 4'd1;
        if (bc >= BITC_FULL) begin
          rb = sh;
        end
      end
      if (tmr <= 8'd1) begin
        go = 1'b1;
        case (stp)
          ST_S_A: tgt = ST_S_B;
          ST_S_B: tgt = ST_S_C;
          ST_S_C: tgt = ST_S_D;
          ST_P_A: tgt = ST_P_B;
          ST_P_B: tgt = ST_P_C;
          ST_W_A: tgt = ST_W_B;
          ST_W_B: tgt = ST_W_C;
          ST_K_A: tgt = ST_K_B;
          ST_K_B: tgt = ST_POLL;
          ST_R_A: tgt = ST_R_B;
          ST_A_A: tgt = ST_A_B;
          ST_W_C: begin
            sh  = {sh[6:0], 1'b0};
            bc  = bc + 4'd1;
            tgt = (bc >= BITC_FULL) ? ST_K_A : ST_W_A;
          end
          ST_R_B: tgt = (bc >= BITC_FULL) ? ST_A_A : ST_R_A;
          ST_S_D, ST_P_C: begin
            go  = 1'b0;
            stp = ST_FIN;
            tmr = 8'd0;
          end
          ST_A_B: begin
            go     = 1'b0;
            ln.scl = 1'b0;
            stp    = ST_FIN;
            tmr    = 8'd0;
          end
          default: begin
            go  = 1'b0;
            stp = ST_IDLE;
            tmr = 8'd0;
          end
        endcase
      end else begin
        tmr = tmr - 8'd1;
      end
    end

    if (go) begin
      e   = enter_st(tgt, ln, sh[7], ak);
      stp = e.step;
      tmr = e.timer;
      ln  = e.line;
    end

    step_nxt  = stp;
    timer_nxt = tmr;
    bitc_nxt  = bc;
    shift_nxt = sh;
    ackr_nxt  = ak;
    line_nxt  = ln;
    nack_nxt  = nk;
    rbyte_nxt = rb;

    res.scl_out   = oln.scl;
    res.sda_out   = oln.sda;
    res.sda_drive = oln.drv;
    res.busy_res  = busy;
    res.done_res  = done;
    res.read_data = rb;
    res.nack      = nk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      timer_r <= 8'd0;
      bitc_r  <= 4'd0;
      shift_r <= 8'd0;
      ackr_r  <= 1'b0;
      line_r  <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      nack_r  <= 1'b0;
      rbyte_r <= 8'd0;
    end else if (fire) begin
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
      bitc_r  <= bitc_nxt;
      shift_r <= shift_nxt;
      ackr_r  <= ackr_nxt;
      line_r  <= line_nxt;
      nack_r  <= nack_nxt;
      rbyte_r <= rbyte_nxt;
    end
  end

  `I2CBL_ASSERT(a_busy_done_excl, !(res.busy_res && res.done_res))
  `I2CBL_ASSERT(a_poll_lines, (fire && step_r == ST_POLL) |-> (res.scl_out && !res.sda_drive))
  `I2CBL_ASSERT(a_done_to_idle, (fire && res.done_res) |=> (step_r == ST_IDLE))

endmodule

/* hdl/i2c_bit_level_master_unit.sv */
// Top level of the I2C bit-level master: config register, item pipeline and sequencer.
//
// Tick-driven I2C master line sequencer. Every input item is one timing tick
// (nominally one microsecond) and produces exactly one result item that gives
// the SCL level, the SDA level and whether SDA is driven, together with busy
// and done flags, the last byte read and the nack flag. A command in the item
// (start, stop, write a byte and wait for the acknowledge, read a byte and send
// ACK or NACK) is taken only on a tick at which the sequencer is idle; on the
// done tick and while busy the command is ignored. The block sustains one item
// per clock cycle while the result side is not stalling: an accepted item is
// registered in the input register, stepped through the combinational sequencer
// and registered in the result register, from which its result is offered.
// That rate is set by the sequencer's registered state update, which every tick
// depends on. When the result register is full and stalled, the input register
// still takes one more item. The acknowledge timeout (cfg_wr_data, reset 250)
// may only be written while no item is in flight; the acknowledge wait gives
// up after SDA is seen high on timeout plus one polling ticks, runs a full stop
// sequence and raises nack.
`include "i2c_bit_level_master_unit_macros.svh"

module i2c_bit_level_master_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cbl_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cbl_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);
  import i2cbl_pkg::*;

  logic [7:0] ack_timeout_r;
  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  step_res;
  logic       out_free;
  logic       move;
  logic       in_take;

  // The result register can take a new item when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  // The item in the input register is stepped through the sequencer on move.
  assign move     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      ack_timeout_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  i2cbl_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (move),
    .item        (in_item_r),
    .ack_timeout (ack_timeout_r),
    .res         (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `I2CBL_ASSERT(a_move_loads_result, move |=> out_valid_r)
  `I2CBL_ASSERT(a_stall_needs_item, in_stall |-> (in_valid_r && out_valid_r))
  `I2CBL_ASSERT_NR(a_reset_empty, !$past(rst_n) |-> (!out_valid_r && !in_valid_r))

endmodule
